// ----- sv/lrts_pkg.sv -----
// Shared constants, types and the CORDIC arctangent table for the lidar ring
// yaw time stamper. No dependencies.
`default_nettype none

package lrts_pkg;

  localparam int RINGS_DEF    = 16;
  localparam int COORD_W      = 19;
  localparam int REFL_W       = 8;
  localparam int RING_W       = 4;
  localparam int TIME_W       = 20;
  localparam int CFG_W        = 27;
  localparam int CFG_AW       = 2;
  localparam int BLIND_W      = 27;
  localparam int DEC_W        = 7;
  localparam int PHASE_W      = 6;
  localparam int CORDIC_ITERS = 18;
  localparam int IDX_W        = 5;
  localparam int PRE_SHIFT    = 20;
  localparam int XW           = 42;
  localparam int ZW           = 26;
  localparam int YAW_W        = 17;
  localparam int RND_W        = 18;
  localparam int DIST_W       = 38;
  localparam int D_W          = 17;
  localparam int T1_W         = 18;
  localparam int T2_W         = 19;
  localparam int US_NUM       = 277;
  localparam int RAM_W        = YAW_W + TIME_W;

  localparam logic signed [ZW-1:0]    Z_QUARTER = ZW'(90 * 65536);
  localparam logic signed [RND_W-1:0] HALF_TURN = RND_W'(46080);
  localparam logic signed [RND_W-1:0] TURN      = RND_W'(92160);

  localparam logic [DEC_W-1:0] DEC_MIN = DEC_W'(1);
  localparam logic [DEC_W-1:0] DEC_MAX = DEC_W'(64);

  typedef enum logic [CFG_AW-1:0] {
    CFG_TS_GIVEN = 2'd0,
    CFG_BLIND    = 2'd1,
    CFG_DECIM    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             load;
    logic             pre;
    logic             iter;
    logic [IDX_W-1:0] idx;
    logic             yaw;
    logic             diff;
    logic             mul;
    logic             done;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_lut(input logic [IDX_W-1:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:    a = ZW'(2949120);
      5'd1:    a = ZW'(1740967);
      5'd2:    a = ZW'(919879);
      5'd3:    a = ZW'(466945);
      5'd4:    a = ZW'(234379);
      5'd5:    a = ZW'(117304);
      5'd6:    a = ZW'(58666);
      5'd7:    a = ZW'(29335);
      5'd8:    a = ZW'(14668);
      5'd9:    a = ZW'(7334);
      5'd10:   a = ZW'(3667);
      5'd11:   a = ZW'(1833);
      5'd12:   a = ZW'(917);
      5'd13:   a = ZW'(458);
      5'd14:   a = ZW'(229);
      5'd15:   a = ZW'(115);
      5'd16:   a = ZW'(57);
      5'd17:   a = ZW'(29);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- sv/lrts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sv/lrts_ctrl.sv -----
// Sequencer for the time stamper: accept, pre-rotate, CORDIC iterations,
// yaw, time and write-back steps. Depends on lrts_pkg.
`default_nettype none

module lrts_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire lrts_pkg::sts_t sts_i,
  output lrts_pkg::cmd_t     cmd_o
);

  import lrts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_ITER,
    ST_YAW,
    ST_DIFF,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_PRE;
          end
        end
        ST_PRE: begin
          iter_q  <= '0;
          state_q <= ST_ITER;
        end
        ST_ITER: begin
          if (iter_q == IDX_W'(CORDIC_ITERS - 1)) begin
            state_q <= ST_YAW;
          end else begin
            iter_q <= iter_q + IDX_W'(1);
          end
        end
        ST_YAW:  state_q <= ST_DIFF;
        ST_DIFF: state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_DONE;
        ST_DONE: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.pre  = (state_q == ST_PRE);
    cmd_o.iter = (state_q == ST_ITER);
    cmd_o.idx  = iter_q;
    cmd_o.yaw  = (state_q == ST_YAW);
    cmd_o.diff = (state_q == ST_DIFF);
    cmd_o.mul  = (state_q == ST_MUL);
    cmd_o.done = (state_q == ST_DONE) && sts_i.out_free;
  end

`ifndef SYNTHESIS
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ITER |-> iter_q < IDX_W'(CORDIC_ITERS))
    else $error("CORDIC step index out of range");

  a_load_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_PRE)
    else $error("accepted word did not start processing");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.pre, cmd_o.iter, cmd_o.yaw,
              cmd_o.diff, cmd_o.mul, cmd_o.done}))
    else $error("more than one datapath command active");
`endif

endmodule

`default_nettype wire

// ----- sv/lrts_dp.sv -----
// Datapath: input latch, config registers, shared CORDIC and squarer,
// per-ring state (RAM plus started bits), time math and output register.
// Depends on lrts_pkg and lrts_ram.
`default_nettype none

module lrts_dp #(
  parameter int RINGS = lrts_pkg::RINGS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lrts_pkg::cmd_t                       cmd_i,
  output lrts_pkg::sts_t                            sts_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [lrts_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  wire logic        [lrts_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                                 frame_start_i,
  input  wire logic signed [lrts_pkg::COORD_W-1:0]  pos_x_i,
  input  wire logic signed [lrts_pkg::COORD_W-1:0]  pos_y_i,
  input  wire logic signed [lrts_pkg::COORD_W-1:0]  pos_z_i,
  input  wire logic        [lrts_pkg::REFL_W-1:0]   reflect_i,
  input  wire logic        [lrts_pkg::RING_W-1:0]   laser_ring_i,
  input  wire logic        [lrts_pkg::TIME_W-1:0]   given_time_us_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed      [lrts_pkg::COORD_W-1:0]  out_x_o,
  output logic signed      [lrts_pkg::COORD_W-1:0]  out_y_o,
  output logic signed      [lrts_pkg::COORD_W-1:0]  out_z_o,
  output logic             [lrts_pkg::REFL_W-1:0]   out_intensity_o,
  output logic             [lrts_pkg::TIME_W-1:0]   offset_time_us_o
);

  import lrts_pkg::*;

  localparam int RING_AW = (RINGS > 1) ? $clog2(RINGS) : 1;

  // config
  logic               ts_given_q;
  logic [BLIND_W-1:0] blind_q;
  logic [DEC_W-1:0]   dec_q;

  // latched word
  logic signed [COORD_W-1:0] px_q, py_q, pz_q;
  logic [REFL_W-1:0]         refl_q;
  logic [RING_W-1:0]         ring_q;
  logic [TIME_W-1:0]         gtime_q;
  logic                      phase0_q;
  logic [PHASE_W-1:0]        phase_q;

  // cordic and range
  logic signed [XW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0] cz_q;
  logic                 zero_q;
  logic [DIST_W-1:0]    dist_q;
  logic signed [YAW_W-1:0] yaw_q;

  // time
  logic [D_W-1:0]  d_q;
  logic [T1_W-1:0] t1_q;
  logic [T2_W-1:0] t2_q;

  logic [RINGS-1:0] started_q;
  logic             out_valid_q;

  // ring RAM
  logic [RAM_W-1:0]   ram_rdata;
  logic [RAM_W-1:0]   ram_wdata;
  logic               ram_we;
  logic [RING_AW-1:0] ring_idx;

  logic [DEC_W-1:0]   dec_eff;
  logic [PHASE_W-1:0] phase_cur;
  logic [DEC_W-1:0]   phase_inc;

  logic signed [XW-1:0] px_w, py_w, xs, ys;
  logic signed [ZW-1:0] atan_w, z_rnd;
  logic signed [COORD_W-1:0] sq_op;
  logic signed [2*COORD_W-1:0] sq_prod;
  logic signed [RND_W-1:0] r_w, r_wrap;
  logic signed [YAW_W-1:0] first_yaw;
  logic [TIME_W-1:0]       last_time;
  logic signed [YAW_W+1:0] diff_w;
  logic [T1_W+8-1:0]       p1_w;
  logic [T2_W+8-1:0]       p2_w;
  logic [T2_W-1:0]         d_turn;
  logic [TIME_W-1:0]       t_sel;
  logic                    in_range, started, ring_upd, emit;

  assign ring_idx  = RING_AW'(ring_q);
  assign in_range  = ({28'd0, ring_q} < 32'(RINGS));
  assign started   = started_q[ring_idx];
  assign first_yaw = ram_rdata[RAM_W-1:TIME_W];
  assign last_time = ram_rdata[TIME_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_given_q <= 1'b0;
      blind_q    <= BLIND_W'(10000);
      dec_q      <= DEC_MIN;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TS_GIVEN: ts_given_q <= cfg_wdata_i[0];
        CFG_BLIND:    blind_q    <= cfg_wdata_i[BLIND_W-1:0];
        CFG_DECIM:    dec_q      <= cfg_wdata_i[DEC_W-1:0];
        default: ;
      endcase
    end
  end

  // decimation phase
  always_comb begin
    if (dec_q == '0) begin
      dec_eff = DEC_MIN;
    end else if (dec_q > DEC_MAX) begin
      dec_eff = DEC_MAX;
    end else begin
      dec_eff = dec_q;
    end
    phase_cur = frame_start_i ? '0 : phase_q;
    phase_inc = {1'b0, phase_cur} + DEC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      started_q <= '0;
    end else begin
      if (cmd_i.load) begin
        phase_q <= (phase_inc >= dec_eff) ? '0 : phase_inc[PHASE_W-1:0];
        if (frame_start_i) begin
          started_q <= '0;
        end
      end
      if (cmd_i.done && ring_upd) begin
        started_q[ring_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q     <= pos_x_i;
      py_q     <= pos_y_i;
      pz_q     <= pos_z_i;
      refl_q   <= reflect_i;
      ring_q   <= laser_ring_i;
      gtime_q  <= given_time_us_i;
      phase0_q <= (phase_cur == '0);
    end
  end

  // CORDIC vectoring and squared range
  assign px_w   = XW'(px_q) <<< PRE_SHIFT;
  assign py_w   = XW'(py_q) <<< PRE_SHIFT;
  assign xs     = cx_q >>> cmd_i.idx;
  assign ys     = cy_q >>> cmd_i.idx;
  assign atan_w = atan_lut(cmd_i.idx);

  always_comb begin
    if (cmd_i.idx == '0) begin
      sq_op = px_q;
    end else if (cmd_i.idx == IDX_W'(1)) begin
      sq_op = py_q;
    end else begin
      sq_op = pz_q;
    end
    sq_prod = sq_op * sq_op;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pre) begin
      zero_q <= (px_q == '0) && (py_q == '0);
      if (px_q[COORD_W-1]) begin
        if (!py_q[COORD_W-1]) begin
          cx_q <= py_w;
          cy_q <= -px_w;
          cz_q <= Z_QUARTER;
        end else begin
          cx_q <= -py_w;
          cy_q <= px_w;
          cz_q <= -Z_QUARTER;
        end
      end else begin
        cx_q <= px_w;
        cy_q <= py_w;
        cz_q <= '0;
      end
    end else if (cmd_i.iter) begin
      if (!cy_q[XW-1]) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atan_w;
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atan_w;
      end
      if (cmd_i.idx == '0) begin
        dist_q <= DIST_W'(unsigned'(sq_prod));
      end else if (cmd_i.idx <= IDX_W'(2)) begin
        dist_q <= dist_q + DIST_W'(unsigned'(sq_prod));
      end
    end
  end

  // yaw in 1/256 degree, wrapped into one turn
  always_comb begin
    z_rnd = cz_q + ZW'(128);
    r_w   = RND_W'(z_rnd >>> 8);
    if (r_w > HALF_TURN) begin
      r_wrap = r_w - TURN;
    end else if (r_w < -HALF_TURN) begin
      r_wrap = r_w + TURN;
    end else begin
      r_wrap = r_w;
    end
  end

  always_comb begin
    diff_w = (YAW_W+2)'(first_yaw) - (YAW_W+2)'(yaw_q);
    if (yaw_q > first_yaw) begin
      diff_w = diff_w + (YAW_W+2)'(TURN);
    end
    d_turn = T2_W'(d_q) + T2_W'(TURN);
    p1_w   = (T1_W+8)'(d_q) * (T1_W+8)'(US_NUM);
    p2_w   = (T2_W+8)'(d_turn) * (T2_W+8)'(US_NUM);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.yaw) begin
      yaw_q <= zero_q ? '0 : YAW_W'(r_wrap);
    end
    if (cmd_i.diff) begin
      d_q <= D_W'(diff_w);
    end
    if (cmd_i.mul) begin
      t1_q <= p1_w[T1_W+8-1:8];
      t2_q <= p2_w[T2_W+8-1:8];
    end
  end

  // write-back and result
  always_comb begin
    t_sel     = (TIME_W'(t1_q) < last_time) ? TIME_W'(t2_q) : TIME_W'(t1_q);
    ring_upd  = !ts_given_q && in_range;
    ram_we    = cmd_i.done && ring_upd;
    ram_wdata = started ? {first_yaw, t_sel} : {yaw_q, {TIME_W{1'b0}}};
    emit      = (ts_given_q || (in_range && started)) && phase0_q &&
                (dist_q > DIST_W'(blind_q));
  end

  lrts_ram #(
    .WIDTH (RAM_W),
    .DEPTH (RINGS)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ring_idx),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.pre),
    .raddr_i (ring_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.done) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done && emit) begin
      out_x_o          <= px_q;
      out_y_o          <= py_q;
      out_z_o          <= pz_q;
      out_intensity_o  <= refl_q;
      offset_time_us_o <= ts_given_q ? gtime_q : t_sel;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

`ifndef SYNTHESIS
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && frame_start_i |=> started_q == '0)
    else $error("frame start did not clear ring state");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.yaw |=> (yaw_q <= YAW_W'(HALF_TURN)) && (yaw_q >= -YAW_W'(HALF_TURN)))
    else $error("yaw outside one turn");

  a_drop_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.done && !phase0_q |=> !out_valid_q)
    else $error("decimated word was emitted");
`endif

endmodule

`default_nettype wire

// ----- sv/lidar_ring_yaw_time_stamper.sv -----
// Each accepted word runs pre-rotate, the 18-step shared CORDIC unit, yaw, time and
// write-back; no new word is accepted until write-back, which waits on a stalled output.
// A finished word waits in the output register while the next word is accepted.
// Reset clears config (timestamps_given 0, blind_radius_sq 10000, decimation 1),
// ring started bits and the decimation phase; ring RAM needs no clearing.
`default_nettype none

module lidar_ring_yaw_time_stamper #(
  parameter int RINGS = lrts_pkg::RINGS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [lrts_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  wire logic        [lrts_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 frame_start_i,
  input  wire logic signed [lrts_pkg::COORD_W-1:0]  pos_x_i,
  input  wire logic signed [lrts_pkg::COORD_W-1:0]  pos_y_i,
  input  wire logic signed [lrts_pkg::COORD_W-1:0]  pos_z_i,
  input  wire logic        [lrts_pkg::REFL_W-1:0]   reflect_i,
  input  wire logic        [lrts_pkg::RING_W-1:0]   laser_ring_i,
  input  wire logic        [lrts_pkg::TIME_W-1:0]   given_time_us_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed      [lrts_pkg::COORD_W-1:0]  out_x_o,
  output logic signed      [lrts_pkg::COORD_W-1:0]  out_y_o,
  output logic signed      [lrts_pkg::COORD_W-1:0]  out_z_o,
  output logic             [lrts_pkg::REFL_W-1:0]   out_intensity_o,
  output logic             [lrts_pkg::TIME_W-1:0]   offset_time_us_o
);

  import lrts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrts_dp #(
    .RINGS (RINGS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .frame_start_i    (frame_start_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .reflect_i        (reflect_i),
    .laser_ring_i     (laser_ring_i),
    .given_time_us_i  (given_time_us_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_z_o          (out_z_o),
    .out_intensity_o  (out_intensity_o),
    .offset_time_us_o (offset_time_us_o)
  );

endmodule

`default_nettype wire
